// ===== rtl/small_isa_processor_core_top_macros.svh =====
// Assertion macros shared by the core RTL.
// Depends on nothing; included by the files that assert.
`ifndef SMALL_ISA_PROCESSOR_CORE_TOP_MACROS_SVH
`define SMALL_ISA_PROCESSOR_CORE_TOP_MACROS_SVH
// implication checked on every clock edge outside reset
`define SIP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define SIP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== rtl/sip_pkg.sv =====
// Package for the small processor core: sizes, opcodes, sequencer states.
// Depends on nothing.
package sip_pkg;
  localparam int MemDepth = 2048;
  localparam int AddrW = $clog2(MemDepth);
  localparam int ClearCycles = MemDepth;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_MOVI = 4'd3,
    OP_JEQ = 4'd4, OP_AND = 4'd5, OP_XORI = 4'd6, OP_JMP = 4'd7,
    OP_LSL = 4'd8, OP_LSR = 4'd9, OP_LD = 4'd10, OP_ST = 4'd11,
    OP_N12 = 4'd12, OP_N13 = 4'd13, OP_N14 = 4'd14, OP_N15 = 4'd15
  } opcode_t;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_FETCH, ST_DECODE, ST_EXEC, ST_MEM, ST_DONE
  } state_t;

  typedef enum logic [1:0] {ALU_ADD, ALU_SUB, ALU_AND, ALU_XOR} alu_op_t;
endpackage

// ===== rtl/sip_alu.sv =====
// Shared arithmetic unit of the core: add, subtract, logic, shifts, multiply.
// Depends on sip_pkg.
module sip_alu (
  input  sip_pkg::opcode_t op,
  input  logic [31:0]      a,
  input  logic [31:0]      b,
  input  logic [12:0]      shamt,
  output logic [31:0]      res
);
  import sip_pkg::*;
  logic [31:0] prod;
  assign prod = a * b;
  always_comb begin
    unique case (op)
      OP_SUB:  res = a - b;
      OP_MUL:  res = prod;
      OP_AND:  res = a & b;
      OP_XORI: res = a ^ b;
      OP_LSL:  res = (shamt >= 13'd32) ? 32'd0 : (a << shamt[4:0]);
      OP_LSR:  res = (shamt >= 13'd32) ? 32'd0 : (a >> shamt[4:0]);
      default: res = a + b;
    endcase
  end
endmodule

// ===== rtl/small_isa_processor_core_top.sv =====
// Top level of the small processor core: sequencer, register file, memory.
// Depends on sip_pkg, sip_alu and the assertion macro header.
//
// Usage: raise start with kind, load_address and load_word while busy is
// low. kind 0 writes one memory word; kind 1 runs the instruction at the
// program counter. Each request yields one result, shown for one cycle with
// done high; the receiver cannot stall it and none is needed.
// Timing: a load request reaches done in the cycle after acceptance; a
// step passes fetch, decode and register read, execute, and memory with
// write back, then done, an order set by the synchronous memory read in
// fetch and again for loads. busy goes high after acceptance and stays
// high through done, so requests run one at a time.
// Reset: register file, pc and clear counter clear at once; the word
// memory is cleared by a pass over all 2048 words, one word a cycle, with busy high.
module small_isa_processor_core_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        kind,
  input  logic [10:0] load_address,
  input  logic [31:0] load_word,
  output logic        done,
  output logic [10:0] pc_after,
  output logic [3:0]  opcode_seen,
  output logic        reg_written,
  output logic [4:0]  reg_index,
  output logic [31:0] reg_value,
  output logic        mem_written,
  output logic [10:0] mem_address,
  output logic [31:0] mem_value,
  output logic        branch_taken,
  output logic        unknown_opcode
);
  import sip_pkg::*;
  `include "small_isa_processor_core_top_macros.svh"

  state_t state, state_next;
  logic [31:0] mem [MemDepth];
  logic [31:0] regs [32];
  logic [31:0] rdata;
  logic [AddrW-1:0] raddr, waddr;
  logic [31:0] wdata;
  logic        we;
  logic [AddrW:0] clr_cnt;
  logic [AddrW-1:0] pc;
  logic [31:0] ins, a, b, c, res;
  opcode_t     op;
  logic        is_load;
  logic        accept;

  // result registers
  logic        o_rw, o_mw, o_br, o_unk;
  logic [4:0]  o_ri;
  logic [31:0] o_rv, o_mv;
  logic [AddrW-1:0] o_ma;
  logic [3:0]  o_op;

  assign accept = start && !busy;
  assign op = opcode_t'(ins[31:28]);

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (clr_cnt == (AddrW+1)'(ClearCycles - 1)) state_next = ST_IDLE;
      ST_IDLE:   if (accept) state_next = kind ? ST_FETCH : ST_DONE;
      ST_FETCH:  state_next = ST_DECODE;
      ST_DECODE: state_next = ST_EXEC;
      ST_EXEC:   state_next = ST_MEM;
      ST_MEM:    state_next = ST_DONE;
      ST_DONE:   state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy = (state != ST_IDLE);
    done = (state == ST_DONE);
  end

  // memory port control
  always_comb begin
    we = 1'b0;
    waddr = clr_cnt[AddrW-1:0];
    wdata = 32'd0;
    raddr = pc;
    if (state == ST_CLEAR) begin
      we = 1'b1;
    end else if (accept && !kind) begin
      we = 1'b1;
      waddr = load_address[AddrW-1:0];
      wdata = load_word;
    end else if (state == ST_EXEC) begin
      raddr = res[AddrW-1:0];
      if (op == OP_ST) begin
        we = 1'b1;
        waddr = res[AddrW-1:0];
        wdata = c;
      end
    end
  end

  sip_alu u_alu (
    .op    (op),
    .a     (a),
    .b     ((op == OP_XORI || op == OP_LD || op == OP_ST) ?
            {14'd0, ins[17:0]} : b),
    .shamt (ins[12:0]),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_cnt <= '0;
      pc <= '0;
      for (int i = 0; i < 32; i++) regs[i] <= 32'd0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      if (accept) begin
        is_load <= !kind;
        o_rw <= 1'b0; o_ri <= '0; o_rv <= '0; o_br <= 1'b0; o_unk <= 1'b0;
        o_op <= '0;
        o_mw <= !kind;
        o_ma <= kind ? '0 : load_address[AddrW-1:0];
        o_mv <= kind ? 32'd0 : load_word;
      end
      if (state == ST_FETCH) pc <= pc + 1'b1;
      if (state == ST_DECODE) begin
        ins <= rdata;
        a <= (rdata[22:18] == 5'd0) ? 32'd0 : regs[rdata[22:18]];
        b <= (rdata[17:13] == 5'd0) ? 32'd0 : regs[rdata[17:13]];
        c <= (rdata[27:23] == 5'd0) ? 32'd0 : regs[rdata[27:23]];
      end
      if (state == ST_EXEC) begin
        o_op <= ins[31:28];
        o_unk <= (op == OP_N12 || op == OP_N13 || op == OP_N14 || op == OP_N15);
        if (op == OP_JEQ && c == a) begin
          pc <= pc + ins[AddrW-1:0];
          o_br <= 1'b1;
        end
        if (op == OP_JMP) begin
          pc <= ins[AddrW-1:0];
          o_br <= 1'b1;
        end
        if (op == OP_ST) begin
          o_mw <= 1'b1;
          o_ma <= res[AddrW-1:0];
          o_mv <= c;
        end
        o_rv <= (op == OP_MOVI) ? {14'd0, ins[17:0]} : res;
      end
      if (state == ST_MEM) begin
        if (ins[27:23] != 5'd0 && (op != OP_JEQ && op != OP_JMP && op != OP_ST &&
            op != OP_N12 && op != OP_N13 && op != OP_N14 && op != OP_N15)) begin
          o_rw <= 1'b1;
          o_ri <= ins[27:23];
          if (op == OP_LD) begin
            o_rv <= rdata;
            regs[ins[27:23]] <= rdata;
          end else begin
            regs[ins[27:23]] <= o_rv;
          end
        end else begin
          o_rv <= 32'd0;
        end
      end
    end
  end

  assign pc_after = pc;
  assign opcode_seen = o_op;
  assign reg_written = o_rw;
  assign reg_index = o_ri;
  assign reg_value = o_rv;
  assign mem_written = o_mw;
  assign mem_address = o_ma;
  assign mem_value = o_mv;
  assign branch_taken = o_br;
  assign unknown_opcode = o_unk;

  `SIP_ASSERT_NXT(a_done_one, done, !done, "done held for more than one cycle")
  `SIP_ASSERT_IMP(a_busy_done, done, busy, "done outside a busy request")
  `SIP_ASSERT_IMP(a_load_nobr, done && is_load, !o_br && !o_rw, "load item changed regs")
  `SIP_ASSERT_IMP(a_r0, done && o_rw, o_ri != 5'd0, "register zero written")
endmodule
